// ===== rtl/alir_pkg.sv =====
// Shared types and constants for the array list block.
// Depends on nothing; imported by every module under rtl/.
package alir_pkg;

  // List capacity and stored word width
  localparam int DEPTH      = 512;
  localparam int DATA_WIDTH = 32;

  // Fixed port field widths
  localparam int OP_W  = 3;
  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  // Derived widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Registered 8-way OR tree that reads the removed word out of the row
  localparam int TREE_FAN    = 8;
  localparam int TREE_LVL    = (IDX_W + 2) / 3;
  localparam int TREE_LEAVES = 1 << (3 * TREE_LVL);
  localparam int TREE_NODES  = (TREE_LEAVES - 1) / (TREE_FAN - 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_REM_POS   = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] removed_value;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] entry_count;
  } result_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] word;
  } cell_ctl_t;

endpackage

// ===== rtl/array_list_insert_remove.sv =====
// Top level of the packed array list: control, status and the cell row.
// Depends on alir_pkg, alir_cell and alir_sel_tree.
//
//  channel   direction  handshake          payload
//  command   in         start / busy       cmd    (operation, position, entry_value)
//  result    out        done (one cycle)   result (removed_value, status, entry_count)
//
// A command transaction is taken at an edge with start high and busy low.
// The whole row of cells shifts in that same edge. The removed word then
// climbs the registered 8-way OR tree (TREE_LVL levels, 3 at 512 entries);
// done pulses as result takes the word from the tree root, and busy drops
// together with done, so no new command is taken while one is in flight.
// Synchronous active-high rst empties the list; the stored words are not
// cleared, since only slots below the count are ever read.
// The receiver cannot stall: result is valid only in the cycle done is high.
module array_list_insert_remove (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  alir_pkg::cmd_t    cmd,
  output logic              done,
  output alir_pkg::result_t result
);
  import alir_pkg::*;

  logic                  accept;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [TREE_LVL-1:0]   vld;          // one bit per tree level in flight
  logic [ST_W-1:0]       pend_status;
  logic                  pend_take;

  // Decode of the incoming command against the current count
  logic [ST_W-1:0]       st_dec;
  logic                  ins_dec;
  logic                  rem_dec;
  logic [IDX_W-1:0]      pos_dec;

  cell_ctl_t             ctl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] root;

  assign accept = start && !busy;
  assign busy   = |vld;

  always_comb begin
    st_dec  = ST_OK;
    ins_dec = 1'b0;
    rem_dec = 1'b0;
    pos_dec = '0;
    if (cmd.operation inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_POS}) begin
      case (cmd.operation)
        OP_INS_BACK: pos_dec = IDX_W'(count);
        OP_INS_POS:  pos_dec = IDX_W'(cmd.position);
        default:     pos_dec = '0;
      endcase
      if (count == CNT_W'(DEPTH)) begin
        st_dec = ST_FULL;
      end else if (cmd.operation == OP_INS_POS &&
                   CMP_W'(cmd.position) > CMP_W'(count)) begin
        st_dec = ST_BADPOS;
      end else begin
        ins_dec = 1'b1;
      end
    end else if (cmd.operation inside {OP_REM_FRONT, OP_REM_BACK, OP_REM_POS}) begin
      case (cmd.operation)
        OP_REM_BACK: pos_dec = IDX_W'(count - CNT_W'(1));
        OP_REM_POS:  pos_dec = IDX_W'(cmd.position);
        default:     pos_dec = '0;
      endcase
      if (count == '0) begin
        // empty wins over a bad position
        st_dec = ST_EMPTY;
      end else if (cmd.operation == OP_REM_POS &&
                   CMP_W'(cmd.position) >= CMP_W'(count)) begin
        st_dec = ST_BADPOS;
      end else begin
        rem_dec = 1'b1;
      end
    end
    // undefined operation codes fall through: status ok, nothing moves
  end

  always_comb begin
    count_next = count;
    if (accept && ins_dec) begin
      count_next = count + CNT_W'(1);
    end else if (accept && rem_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign ctl.ins  = accept && ins_dec;
  assign ctl.rem  = accept && rem_dec;
  assign ctl.pos  = pos_dec;
  assign ctl.word = DATA_WIDTH'(cmd.entry_value);

  // Row of cells; inserts pull from the left, removes from the right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    alir_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // Taps are sampled at the command edge, before the shift is seen
  alir_sel_tree u_tree (
    .clk  (clk),
    .leaf (cell_tap),
    .root (root)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      vld   <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      vld   <= TREE_LVL'({vld, accept});
      done  <= vld[TREE_LVL-1];
    end
  end

  // Transaction bookkeeping while the word travels up the tree
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st_dec;
      pend_take   <= rem_dec;
    end
    if (vld[TREE_LVL-1]) begin
      result.removed_value <= pend_take ? VAL_W'(root) : '0;
      result.status        <= pend_status;
      result.entry_count   <= POS_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  // busy must rise after a command transaction is taken
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after a command transaction");

  // at most one command in flight
  assert property (@(posedge clk) disable iff (rst) $onehot0(vld))
    else $error("more than one command in the tree pipeline");

  // list never grows past capacity
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // failed results carry no word
  assert property (@(posedge clk) disable iff (rst)
                   done && result.status != ST_OK |-> result.removed_value == '0)
    else $error("removed word on a failed operation");
`endif

endmodule

// ===== rtl/alir_cell.sv =====
// One list slot: holds a word, shifts from its left or right neighbor.
// Depends on alir_pkg.
module alir_cell (
  input  logic                           clk,
  input  logic [alir_pkg::IDX_W-1:0]      idx,
  input  alir_pkg::cell_ctl_t            ctl,
  input  logic [alir_pkg::DATA_WIDTH-1:0] left,
  input  logic [alir_pkg::DATA_WIDTH-1:0] right,
  output logic [alir_pkg::DATA_WIDTH-1:0] data,
  output logic [alir_pkg::DATA_WIDTH-1:0] tap
);
  import alir_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (idx > ctl.pos) begin
        data <= left;
      end else if (idx == ctl.pos) begin
        data <= ctl.word;
      end
    end else if (ctl.rem) begin
      if (idx >= ctl.pos) begin
        data <= right;
      end
    end
  end

  // Word at the addressed slot, zero elsewhere; feeds the OR tree
  assign tap = (idx == ctl.pos) ? data : '0;

endmodule

// ===== rtl/alir_sel_tree.sv =====
// Pipelined 8-way OR tree collecting the one non-zero tap of the row.
// Depends on alir_pkg. One register level per 8-way stage.
module alir_sel_tree (
  input  logic                           clk,
  input  logic [alir_pkg::DATA_WIDTH-1:0] leaf [alir_pkg::DEPTH],
  output logic [alir_pkg::DATA_WIDTH-1:0] root
);
  import alir_pkg::*;

  // Heap order: node n has children 8n+1 .. 8n+8, leaves follow the nodes
  logic [DATA_WIDTH-1:0] node [TREE_NODES];

  for (genvar n = 0; n < TREE_NODES; n++) begin : g_node
    logic [DATA_WIDTH-1:0] kid [TREE_FAN];
    logic [DATA_WIDTH-1:0] acc;

    for (genvar c = 0; c < TREE_FAN; c++) begin : g_kid
      localparam int CHILD = TREE_FAN * n + 1 + c;
      if (CHILD < TREE_NODES) begin : g_inner
        assign kid[c] = node[CHILD];
      end else if (CHILD - TREE_NODES < DEPTH) begin : g_leaf
        assign kid[c] = leaf[CHILD - TREE_NODES];
      end else begin : g_pad
        assign kid[c] = '0;
      end
    end

    always_comb begin
      acc = '0;
      for (int c = 0; c < TREE_FAN; c++) begin
        acc = acc | kid[c];
      end
    end

    always_ff @(posedge clk) begin
      node[n] <= acc;
    end
  end

  assign root = node[0];

endmodule
